[rtl/bmpu_pkg.sv]
// Shared types, constants and helpers for the bitmap pixel unpacker.
// Used by every module in rtl/; has no dependencies of its own.
package bmpu_pkg;

  localparam int MaxWidth  = 4096;
  localparam int MaxHeight = 4096;

  localparam int DimW     = 13;   // width and height register size
  localparam int CoordW   = 12;   // column and row output size
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 32;
  localparam int PosW     = 3;    // byte position 0..3, or none
  localparam int OutDataW = 56;   // red, green, blue, alpha, column, row

  localparam logic [DimW-1:0] MaxWidthDim  = DimW'(MaxWidth);
  localparam logic [DimW-1:0] MaxHeightDim = DimW'(MaxHeight);

  localparam logic [PosW-1:0] PosNone = 3'd4;
  localparam logic [7:0]      NoByte  = 8'hff;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_WIDTH   = 3'd0,
    CFG_HEIGHT  = 3'd1,
    CFG_TOPDOWN = 3'd2,
    CFG_FORMAT  = 3'd3,
    CFG_RMASK   = 3'd4,
    CFG_GMASK   = 3'd5,
    CFG_BMASK   = 3'd6,
    CFG_AMASK   = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [DimW-1:0] width;      // clamped to 1..MaxWidth
    logic [DimW-1:0] height;     // clamped to 1..MaxHeight
    logic            top_down;
    logic            wide;       // 4 bytes per pixel
    logic [PosW-1:0] red_pos;
    logic [PosW-1:0] green_pos;
    logic [PosW-1:0] blue_pos;
    logic [PosW-1:0] alpha_pos;
  } cfg_t;

  typedef struct packed {
    logic fire;   // item in the input register is consumed this cycle
    logic pad;    // item is a row padding byte
    logic done;   // item completes a pixel
  } ctrl_t;

  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  function automatic logic [PosW-1:0] decode_mask(input logic [31:0] m);
    logic [PosW-1:0] p;
    case (m)
      32'hff000000: p = 3'd3;
      32'h00ff0000: p = 3'd2;
      32'h0000ff00: p = 3'd1;
      32'h000000ff: p = 3'd0;
      default:      p = PosNone;
    endcase
    return p;
  endfunction

  function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] v,
                                               input logic [DimW-1:0] maxv);
    logic [DimW-1:0] r;
    if (v == '0) r = DimW'(1);
    else if (v > maxv) r = maxv;
    else r = v;
    return r;
  endfunction

endpackage

[rtl/bmpu_cfg.sv]
// Configuration registers for the bitmap pixel unpacker.
// Decodes dimensions and channel byte positions; depends on bmpu_pkg.
module bmpu_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bmpu_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [bmpu_pkg::CfgDataW-1:0]  cfg_wdata_i,
  output bmpu_pkg::cfg_t                 cfg_o
);

  logic [bmpu_pkg::DimW-1:0] width_q, height_q;
  logic                      top_down_q;
  logic [1:0]                format_q;
  logic [31:0]               rmask_q, gmask_q, bmask_q, amask_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= bmpu_pkg::DimW'(1);
      height_q   <= bmpu_pkg::DimW'(1);
      top_down_q <= 1'b0;
      format_q   <= 2'd1;
      rmask_q    <= 32'h00ff0000;
      gmask_q    <= 32'h0000ff00;
      bmask_q    <= 32'h000000ff;
      amask_q    <= 32'hff000000;
    end else if (cfg_we_i) begin
      unique case (bmpu_pkg::cfg_idx_e'(cfg_idx_i))
        bmpu_pkg::CFG_WIDTH:   width_q    <= cfg_wdata_i[bmpu_pkg::DimW-1:0];
        bmpu_pkg::CFG_HEIGHT:  height_q   <= cfg_wdata_i[bmpu_pkg::DimW-1:0];
        bmpu_pkg::CFG_TOPDOWN: top_down_q <= cfg_wdata_i[0];
        bmpu_pkg::CFG_FORMAT:  format_q   <= cfg_wdata_i[1:0];
        bmpu_pkg::CFG_RMASK:   rmask_q    <= cfg_wdata_i;
        bmpu_pkg::CFG_GMASK:   gmask_q    <= cfg_wdata_i;
        bmpu_pkg::CFG_BMASK:   bmask_q    <= cfg_wdata_i;
        bmpu_pkg::CFG_AMASK:   amask_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_o.width    = bmpu_pkg::clamp_dim(width_q, bmpu_pkg::MaxWidthDim);
    cfg_o.height   = bmpu_pkg::clamp_dim(height_q, bmpu_pkg::MaxHeightDim);
    cfg_o.top_down = top_down_q;
    cfg_o.wide     = format_q[0];
    if (format_q[1]) begin
      cfg_o.red_pos   = bmpu_pkg::decode_mask(rmask_q);
      cfg_o.green_pos = bmpu_pkg::decode_mask(gmask_q);
      cfg_o.blue_pos  = bmpu_pkg::decode_mask(bmask_q);
      cfg_o.alpha_pos = bmpu_pkg::decode_mask(amask_q);
    end else begin
      cfg_o.red_pos   = 3'd2;
      cfg_o.green_pos = 3'd1;
      cfg_o.blue_pos  = 3'd0;
      cfg_o.alpha_pos = format_q[0] ? 3'd3 : bmpu_pkg::PosNone;
    end
  end

endmodule

[rtl/bmpu_assemble.sv]
// Pixel byte gathering and channel selection for the bitmap pixel unpacker.
// Depends on bmpu_pkg for the configuration and control structs.
module bmpu_assemble (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bmpu_pkg::cfg_t      cfg_i,
  input  bmpu_pkg::ctrl_t     ctrl_i,
  input  logic [7:0]          byte_i,
  output logic                last_byte_o,
  output bmpu_pkg::pixel_t    pix_o
);

  logic [1:0]      bip_q;
  logic [2:0][7:0] bytes_q;
  logic [2:0]      nbytes;

  assign nbytes      = cfg_i.wide ? 3'd4 : 3'd3;
  assign last_byte_o = ({1'b0, bip_q} + 3'd1) >= nbytes;

  function automatic logic [7:0] pick(input logic [bmpu_pkg::PosW-1:0] pos,
                                      input logic [2:0]                nb,
                                      input logic [1:0]                bip,
                                      input logic [2:0][7:0]           held,
                                      input logic [7:0]                incoming);
    logic [7:0] r;
    if (pos >= nb) r = bmpu_pkg::NoByte;
    else if (pos < {1'b0, bip}) r = held[pos[1:0]];
    else if (pos == {1'b0, bip}) r = incoming;
    else r = bmpu_pkg::NoByte;
    return r;
  endfunction

  always_comb begin
    pix_o.red   = pick(cfg_i.red_pos, nbytes, bip_q, bytes_q, byte_i);
    pix_o.green = pick(cfg_i.green_pos, nbytes, bip_q, bytes_q, byte_i);
    pix_o.blue  = pick(cfg_i.blue_pos, nbytes, bip_q, bytes_q, byte_i);
    pix_o.alpha = pick(cfg_i.alpha_pos, nbytes, bip_q, bytes_q, byte_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bip_q <= 2'd0;
    end else if (ctrl_i.fire && !ctrl_i.pad) begin
      if (ctrl_i.done) bip_q <= 2'd0;
      else bip_q <= bip_q + 2'd1;
    end
  end

  // hold earlier bytes of the pixel; the completing byte is used directly
  always_ff @(posedge clk_i) begin
    if (ctrl_i.fire && !ctrl_i.pad && !ctrl_i.done && bip_q != 2'd3) begin
      bytes_q[bip_q] <= byte_i;
    end
  end

endmodule

[rtl/bmpu_raster.sv]
// Column, row and row padding counters for the bitmap pixel unpacker.
// Produces the destination coordinates; depends on bmpu_pkg.
module bmpu_raster (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bmpu_pkg::cfg_t                cfg_i,
  input  bmpu_pkg::ctrl_t               ctrl_i,
  output logic                          pad_active_o,
  output logic [bmpu_pkg::CoordW-1:0]   column_o,
  output logic [bmpu_pkg::CoordW-1:0]   row_o,
  output logic                          last_o
);

  logic [bmpu_pkg::CoordW-1:0] col_q, row_q;
  logic [1:0]                  pad_q;
  logic [bmpu_pkg::DimW-1:0]   col_ext, row_ext, dest;
  logic                        row_end, img_end;

  assign col_ext = {1'b0, col_q};
  assign row_ext = {1'b0, row_q};

  assign row_end = (col_ext + bmpu_pkg::DimW'(1)) >= cfg_i.width;
  assign img_end = row_end && ((row_ext + bmpu_pkg::DimW'(1)) >= cfg_i.height);

  // flip for bottom-up images; a row past the height lands on row zero
  always_comb begin
    if (cfg_i.top_down) dest = row_ext;
    else if (row_ext < cfg_i.height) dest = cfg_i.height - bmpu_pkg::DimW'(1) - row_ext;
    else dest = '0;
  end

  assign pad_active_o = pad_q != 2'd0;
  assign column_o     = col_q;
  assign row_o        = dest[bmpu_pkg::CoordW-1:0];
  assign last_o       = img_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      pad_q <= 2'd0;
    end else if (ctrl_i.fire) begin
      if (ctrl_i.pad) begin
        pad_q <= pad_q - 2'd1;
      end else if (ctrl_i.done) begin
        if (row_end) begin
          col_q <= '0;
          pad_q <= cfg_i.wide ? 2'd0 : cfg_i.width[1:0];
          row_q <= img_end ? '0 : row_q + bmpu_pkg::CoordW'(1);
        end else begin
          col_q <= col_q + bmpu_pkg::CoordW'(1);
        end
      end
    end
  end

endmodule

[rtl/bmp_pixel_unpacker.sv]
// Bitmap pixel unpacker: takes the stored pixel array of an uncompressed
// 24 or 32 bpp bitmap one byte per item, drops row padding, and emits one
// RGBA item per completed pixel with its column and destination row (flipped
// for bottom-up images); tlast marks the final pixel of the image. Every
// byte passes through an input register and every finished pixel through
// a result register. The block accepts a byte every cycle; only a
// pixel-completing byte waits, and only while a finished pixel sits in the
// result register behind a stalled output. Write configuration only while
// idle. Depends on bmpu_pkg, bmpu_cfg, bmpu_assemble and bmpu_raster.
module bmp_pixel_unpacker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [bmpu_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [bmpu_pkg::CfgDataW-1:0]   cfg_wdata_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,  // [7:0] data_byte
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha,
  // [43:32] column, [55:44] row
  output logic [bmpu_pkg::OutDataW-1:0]   m_axis_tdata,
  output logic                            m_axis_tlast   // last_pixel
);

  bmpu_pkg::cfg_t   cfg;
  bmpu_pkg::ctrl_t  ctrl;
  bmpu_pkg::pixel_t pix;

  logic                        in_valid_q;
  logic [7:0]                  in_data_q;
  logic                        out_valid_q, out_last_q;
  logic [bmpu_pkg::OutDataW-1:0] out_data_q;
  logic                        out_free, pad_active, last_byte, last_pix;
  logic [bmpu_pkg::CoordW-1:0] column, row;

  bmpu_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  assign out_free  = !out_valid_q || m_axis_tready;
  assign ctrl.pad  = pad_active;
  assign ctrl.done = !pad_active && last_byte;
  // stall only a pixel-completing byte while the result register is full and not being drained
  assign ctrl.fire = in_valid_q && (!ctrl.done || out_free);

  assign s_axis_tready = !in_valid_q || ctrl.fire;

  bmpu_assemble u_assemble (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .ctrl_i     (ctrl),
    .byte_i     (in_data_q),
    .last_byte_o(last_byte),
    .pix_o      (pix)
  );

  bmpu_raster u_raster (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .ctrl_i      (ctrl),
    .pad_active_o(pad_active),
    .column_o    (column),
    .row_o       (row),
    .last_o      (last_pix)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) in_valid_q <= s_axis_tvalid;
      if (ctrl.fire && ctrl.done) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) in_data_q <= s_axis_tdata;
    if (ctrl.fire && ctrl.done) begin
      out_data_q <= {row, column, pix.alpha, pix.blue, pix.green, pix.red};
      out_last_q <= last_pix;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

endmodule

[dv/testbench.sv]
// Self-checking testbench for bmp_pixel_unpacker: streams bitmap pixel bytes,
// predicts every RGBA result in SystemVerilog, and checks each field on output.
// Depends on bmpu_pkg and the RTL top level only.
module testbench;
  import bmpu_pkg::*;

  localparam int PixelDimMax  = 4096;
  localparam int NoSlot       = 255;
  localparam int SettleCycles = 6;
  localparam int QuietLimit   = 2000;
  localparam int Segments     = 16;
  localparam int SegmentBytes = 75;
  localparam int WideRowBytes = 24;
  localparam logic [31:0] ByteMask [4] = '{32'h000000ff, 32'h0000ff00,
                                           32'h00ff0000, 32'hff000000};

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [11:0] column;
    logic [11:0] row;
    logic        last;
  } rgba_pixel_t;

  typedef struct {
    bit          is_cfg;
    cfg_idx_e    idx;
    logic [31:0] value;
    logic [7:0]  data;
    bit          typed;
    rgba_pixel_t pixel;
  } stim_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tlast;

  bmp_pixel_unpacker DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #4 clk_i = ~clk_i;

  // Predictor copy of the registers and stream position
  int unsigned img_width  = 1;
  int unsigned img_height = 1;
  bit          rows_top_first = 1'b0;
  logic [1:0]  fmt_bits = 2'b01;
  logic [31:0] chan_mask [4] = '{32'h00ff0000, 32'h0000ff00, 32'h000000ff, 32'hff000000};
  int unsigned byte_pos = 0;
  logic [7:0]  held_bytes [3] = '{8'h00, 8'h00, 8'h00};
  int unsigned col_cnt = 0;
  int unsigned row_cnt = 0;
  int unsigned pad_left = 0;

  rgba_pixel_t expected_pixels [$];
  stim_row_t   directed_rows [$];
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          error_count = 0;
  int          pixels_checked = 0;
  int          bytes_sent = 0;
  int          cfg_writes = 0;
  int          quiet_cycles = 0;

  function automatic int mask_to_slot(input logic [31:0] m);
    case (m)
      32'hff000000: return 3;
      32'h00ff0000: return 2;
      32'h0000ff00: return 1;
      32'h000000ff: return 0;
      default:      return NoSlot;
    endcase
  endfunction

  function automatic int unsigned limit_dim(input int unsigned v);
    if (v == 0) return 1;
    return (v > PixelDimMax) ? PixelDimMax : v;
  endfunction

  // Advance the stream by one byte; return 1 when it completes a pixel
  function automatic bit unpack_byte(input logic [7:0] b, output rgba_pixel_t px);
    int unsigned nbytes;
    int unsigned w;
    int unsigned h;
    int unsigned dest;
    int          slot [4];
    logic [7:0]  chan [4];
    bit          row_end;
    bit          img_end;
    px = '0;
    nbytes = fmt_bits[0] ? 4 : 3;
    w = limit_dim(img_width);
    h = limit_dim(img_height);
    if (pad_left != 0) begin
      pad_left = pad_left - 1;
      return 1'b0;
    end
    if (byte_pos + 1 < nbytes) begin
      if (byte_pos < 3) held_bytes[byte_pos] = b;
      byte_pos = byte_pos + 1;
      return 1'b0;
    end
    if (fmt_bits[1]) begin
      for (int i = 0; i < 4; i++) slot[i] = mask_to_slot(chan_mask[i]);
    end else begin
      slot = '{2, 1, 0, fmt_bits[0] ? 3 : NoSlot};
    end
    // A slot past the pixel or not yet filled reads as all ones
    for (int i = 0; i < 4; i++) begin
      if (slot[i] >= nbytes) chan[i] = 8'hff;
      else if (slot[i] < byte_pos) chan[i] = held_bytes[slot[i]];
      else if (slot[i] == byte_pos) chan[i] = b;
      else chan[i] = 8'hff;
    end
    if (rows_top_first) dest = row_cnt;
    else dest = (row_cnt < h) ? (h - 1 - row_cnt) : 0;
    row_end = (col_cnt + 1 >= w);
    img_end = row_end && (row_cnt + 1 >= h);
    px.red    = chan[0];
    px.green  = chan[1];
    px.blue   = chan[2];
    px.alpha  = chan[3];
    px.column = 12'(col_cnt);
    px.row    = 12'(dest);
    px.last   = img_end;
    byte_pos = 0;
    if (row_end) begin
      col_cnt  = 0;
      pad_left = fmt_bits[0] ? 0 : (w & 3);
      row_cnt  = img_end ? 0 : row_cnt + 1;
    end else begin
      col_cnt = col_cnt + 1;
    end
    return 1'b1;
  endfunction

  function automatic rgba_pixel_t mk_px(input logic [7:0] r, input logic [7:0] g,
                                        input logic [7:0] b, input logic [7:0] a,
                                        input int col, input int row, input bit last);
    rgba_pixel_t px;
    px.red = r; px.green = g; px.blue = b; px.alpha = a;
    px.column = 12'(col); px.row = 12'(row); px.last = last;
    return px;
  endfunction

  function automatic void add_cfg(input cfg_idx_e idx, input logic [31:0] v);
    stim_row_t r;
    r = '{is_cfg: 1'b1, idx: idx, value: v, data: 8'h00, typed: 1'b0, pixel: '0};
    directed_rows.push_back(r);
  endfunction

  function automatic void add_byte(input logic [7:0] b);
    stim_row_t r;
    r = '{is_cfg: 1'b0, idx: CFG_WIDTH, value: '0, data: b, typed: 1'b0, pixel: '0};
    directed_rows.push_back(r);
  endfunction

  function automatic void add_pixel(input logic [7:0] b, input rgba_pixel_t px);
    stim_row_t r;
    r = '{is_cfg: 1'b0, idx: CFG_WIDTH, value: '0, data: b, typed: 1'b1, pixel: px};
    directed_rows.push_back(r);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    error_count++;
    if (error_count <= 100)
      $display("[%0t] MISMATCH pixel %0d %s: got 0x%0h, expected 0x%0h",
               $realtime, pixels_checked, what, got, want);
  endtask

  // Hold the write bus; the register changes at the next edge
  task automatic write_reg(input cfg_idx_e idx, input logic [31:0] v);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_writes++;
    case (idx)
      CFG_WIDTH:   img_width = v[12:0];
      CFG_HEIGHT:  img_height = v[12:0];
      CFG_TOPDOWN: rows_top_first = v[0];
      CFG_FORMAT:  fmt_bits = v[1:0];
      CFG_RMASK:   chan_mask[0] = v;
      CFG_GMASK:   chan_mask[1] = v;
      CFG_BMASK:   chan_mask[2] = v;
      CFG_AMASK:   chan_mask[3] = v;
      default: ;
    endcase
  endtask

  task automatic send_byte(input logic [7:0] b, input bit typed, input rgba_pixel_t typed_px);
    int          gap;
    bit          made;
    rgba_pixel_t px;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    bytes_sent++;
    made = unpack_byte(b, px);
    if (typed) px = typed_px;
    if (made || typed) expected_pixels.push_back(px);
  endtask

  // Stop sending, let every pixel drain, then let dropped bytes clear the pipe
  task automatic quiesce();
    s_axis_tvalid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_mask();
    int r;
    r = $urandom_range(9);
    if (r < 7) return ByteMask[$urandom_range(3)];
    if (r == 7) return $urandom();
    return (r == 8) ? 32'h00000000 : 32'hffffffff;
  endfunction

  function automatic int pick_dim(input bit wide_ok);
    case ($urandom_range(11))
      0: return 0;
      1: return 8191;
      2: return wide_ok ? 4096 : 1;
      default: return wide_ok ? $urandom_range(1, 7) : $urandom_range(1, 4);
    endcase
  endfunction

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    rgba_pixel_t got;
    rgba_pixel_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.red    = m_axis_tdata[7:0];
      got.green  = m_axis_tdata[15:8];
      got.blue   = m_axis_tdata[23:16];
      got.alpha  = m_axis_tdata[31:24];
      got.column = m_axis_tdata[43:32];
      got.row    = m_axis_tdata[55:44];
      got.last   = m_axis_tlast;
      if (expected_pixels.size() == 0) begin
        report_mismatch("unexpected pixel, column", got.column, 0);
      end else begin
        want = expected_pixels.pop_front();
        if (got.red !== want.red) report_mismatch("red", got.red, want.red);
        if (got.green !== want.green) report_mismatch("green", got.green, want.green);
        if (got.blue !== want.blue) report_mismatch("blue", got.blue, want.blue);
        if (got.alpha !== want.alpha) report_mismatch("alpha", got.alpha, want.alpha);
        if (got.column !== want.column) report_mismatch("column", got.column, want.column);
        if (got.row !== want.row) report_mismatch("row", got.row, want.row);
        if (got.last !== want.last) report_mismatch("tlast", got.last, want.last);
      end
      pixels_checked++;
    end
  end

  // End the run if nothing moves on any port for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i)
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
        $display("Timeout: no traffic for %0d cycles", QuietLimit);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    logic [31:0] v;
    // After reset: 32 bpp, fixed layout, 1x1 image
    add_byte(8'h00); add_byte(8'hff); add_byte(8'h00);
    add_pixel(8'hff, mk_px(8'h00, 8'hff, 8'h00, 8'hff, 0, 0, 1));
    // 24 bpp fixed; one padding byte per row
    add_cfg(CFG_FORMAT, 32'd0);
    add_byte(8'h12); add_byte(8'h34);
    add_pixel(8'h56, mk_px(8'h56, 8'h34, 8'h12, 8'hff, 0, 0, 1));
    add_byte(8'haa);
    // 32 bpp masks, unknown alpha mask
    add_cfg(CFG_FORMAT, 32'd3);
    add_cfg(CFG_RMASK, 32'h000000ff);
    add_cfg(CFG_GMASK, 32'hff000000);
    add_cfg(CFG_BMASK, 32'h00ff0000);
    add_cfg(CFG_AMASK, 32'h12345678);
    add_byte(8'h01); add_byte(8'h02); add_byte(8'h03);
    add_pixel(8'h04, mk_px(8'h01, 8'h04, 8'h03, 8'hff, 0, 0, 1));
    // 24 bpp masks: byte 3 lies past the pixel
    add_cfg(CFG_FORMAT, 32'd2);
    add_cfg(CFG_RMASK, 32'h0000ff00);
    add_cfg(CFG_AMASK, 32'hff000000);
    add_byte(8'h80); add_byte(8'h7f);
    add_pixel(8'h55, mk_px(8'h7f, 8'hff, 8'h55, 8'hff, 0, 0, 1));
    add_byte(8'h00);
    // Zero width acts as one, oversize height as the maximum; then drop to
    // 24 bpp while a 4-byte pixel waits for its fourth byte
    add_cfg(CFG_WIDTH, 32'd0);
    add_cfg(CFG_HEIGHT, 32'd8191);
    add_cfg(CFG_FORMAT, 32'd1);
    add_byte(8'ha1); add_byte(8'hb2); add_byte(8'hc3);
    add_cfg(CFG_FORMAT, 32'd0);
    add_pixel(8'hd4, mk_px(8'hc3, 8'hb2, 8'ha1, 8'hff, 0, 4095, 0));
    add_byte(8'h5a);
    // Height shrinks under the current row: flipped row saturates at zero
    add_cfg(CFG_HEIGHT, 32'd1);
    add_byte(8'h0f); add_byte(8'hf0);
    add_pixel(8'h3c, mk_px(8'h3c, 8'hf0, 8'h0f, 8'hff, 0, 0, 1));
    add_byte(8'hc3);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        if (!cfg_we_i) quiesce();
        write_reg(directed_rows[i].idx, directed_rows[i].value);
      end else begin
        if (cfg_we_i) cfg_we_i <= 1'b0;
        send_byte(directed_rows[i].data, directed_rows[i].typed, directed_rows[i].pixel);
      end
    end

    // Largest image, top down: a short run of pixels along the first row
    quiesce();
    write_reg(CFG_WIDTH, 32'd4096);
    write_reg(CFG_HEIGHT, 32'd4096);
    write_reg(CFG_TOPDOWN, 32'd1);
    write_reg(CFG_FORMAT, 32'd0);
    cfg_we_i <= 1'b0;
    for (int n = 0; n < WideRowBytes; n++) send_byte(8'($urandom()), 1'b0, '0);

    for (int seg = 0; seg < Segments; seg++) begin
      quiesce();
      v = $urandom(); v[12:0] = 13'(pick_dim(1'b1)); write_reg(CFG_WIDTH, v);
      v = $urandom(); v[12:0] = 13'(pick_dim(1'b0)); write_reg(CFG_HEIGHT, v);
      v = $urandom(); write_reg(CFG_TOPDOWN, v);
      v = $urandom(); write_reg(CFG_FORMAT, v);
      write_reg(CFG_RMASK, pick_mask());
      write_reg(CFG_GMASK, pick_mask());
      write_reg(CFG_BMASK, pick_mask());
      write_reg(CFG_AMASK, pick_mask());
      cfg_we_i <= 1'b0;
      case (seg % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
        default: begin send_idle_pct = 10; recv_stall_pct = 10; end
      endcase
      for (int n = 0; n < SegmentBytes; n++) begin
        // Now and then hold off until the output side has caught up
        if ($urandom_range(49) == 0) quiesce();
        send_byte(8'($urandom()), 1'b0, '0);
      end
    end

    quiesce();
    $display("Streamed %0d bytes with %0d register writes; %0d pixels compared", bytes_sent,
             cfg_writes, pixels_checked);
    $display("Covered 24/32 bpp, fixed and mask layouts, flips, padding and four stall mixes");
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[files.f]
rtl/bmpu_pkg.sv
rtl/bmpu_cfg.sv
rtl/bmpu_assemble.sv
rtl/bmpu_raster.sv
rtl/bmp_pixel_unpacker.sv
dv/testbench.sv
